### design/pcr_pkg.sv
// Shared types and constants for the pulse counter with rpm measurement.
package pcr_pkg;

  localparam int unsigned CH_W      = 5;
  localparam int unsigned CH_SPACE  = 32;
  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned HOLD_W    = 8;
  localparam int unsigned HOLDCNT_W = 9;
  localparam int unsigned WIN_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 12;

  localparam logic [SAMPLE_W-1:0] HIGH_THR_RST   = 12'd3000;
  localparam logic [SAMPLE_W-1:0] LOW_THR_RST    = 12'd1000;
  localparam logic [HOLD_W-1:0]   CLEAR_HOLD_RST = 8'd20;
  localparam logic [WIN_W-1:0]    RPM_WINDOW_RST = 4'd5;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_RPM    = 2'd2,
    OP_STATUS = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RUN_STOP  = 2'd0,
    RUN_START = 2'd1,
    RUN_CLEAR = 2'd2
  } run_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_THR   = 2'd0,
    CFG_LOW_THR    = 2'd1,
    CFG_CLEAR_HOLD = 2'd2,
    CFG_RPM_WINDOW = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EXEC   = 2'd1,
    ST_DIV    = 2'd2,
    ST_RESULT = 2'd3
  } state_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] high_threshold;
    logic [SAMPLE_W-1:0] low_threshold;
    logic [HOLD_W-1:0]   clear_hold;
    logic [WIN_W-1:0]    rpm_window;
  } cfg_t;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
    logic                count_mode;
    logic                rpm_mode;
    logic [CNT_W-1:0]    now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_channel;
    logic [CNT_W-1:0] pulse_count;
    logic [CNT_W-1:0] rate_rpm;
    logic             level_high;
    logic [1:0]       run_state;
  } out_item_t;

endpackage

### design/pcr_cfg.sv
// Configuration registers for thresholds, clear hold and rpm window.
module pcr_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               we_i,
  input  logic [pcr_pkg::CFG_IDX_W-1:0]      index_i,
  input  logic [pcr_pkg::CFG_DAT_W-1:0]      data_i,
  output pcr_pkg::cfg_t                      cfg_o
);

  pcr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (index_i)
        pcr_pkg::CFG_HIGH_THR:   cfg_d.high_threshold = data_i[pcr_pkg::SAMPLE_W-1:0];
        pcr_pkg::CFG_LOW_THR:    cfg_d.low_threshold  = data_i[pcr_pkg::SAMPLE_W-1:0];
        pcr_pkg::CFG_CLEAR_HOLD: cfg_d.clear_hold     = data_i[pcr_pkg::HOLD_W-1:0];
        pcr_pkg::CFG_RPM_WINDOW: cfg_d.rpm_window     = data_i[pcr_pkg::WIN_W-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_threshold <= pcr_pkg::HIGH_THR_RST;
      cfg_q.low_threshold  <= pcr_pkg::LOW_THR_RST;
      cfg_q.clear_hold     <= pcr_pkg::CLEAR_HOLD_RST;
      cfg_q.rpm_window     <= pcr_pkg::RPM_WINDOW_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/pcr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module pcr_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pcr_pkg::CNT_W-1:0]      dividend_i,
  input  logic [pcr_pkg::CNT_W-1:0]      divisor_i,
  output logic                           done_o,
  output logic [pcr_pkg::CNT_W-1:0]      quotient_o
);

  localparam int unsigned W   = pcr_pkg::CNT_W;
  localparam int unsigned IT_W = $clog2(W);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [IT_W-1:0] iter_q, iter_d;
  logic [W:0]      rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    dsr_q, dsr_d;
  logic [W:0]      rem_sh;
  logic [W:0]      diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    rem_sh = {rem_q[W-1:0], quo_q[W-1]};
    diff   = rem_sh - {1'b0, dsr_q};
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_d = diff;
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      iter_d = iter_q + 1'b1;
      if (iter_q == IT_W'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### design/pulse_counter_with_rpm_core.sv
// Pulse counter with rpm: one item in flight, per-channel state in flops.
// Sample, clear and status items go through EXEC and RESULT; an rpm step
// that divides also waits on the 32-step shared divider. One item at a time.
// The output register lets the next item be taken while a result waits.
// Reset (async, active low) loads register defaults and resets all channels.
module pulse_counter_with_rpm_core #(
  parameter int unsigned CHANNELS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  pcr_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pcr_pkg::out_item_t                out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pcr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pcr_pkg::CFG_DAT_W-1:0]     cfg_data_i
);

  localparam int unsigned DEPTH = (CHANNELS < pcr_pkg::CH_SPACE) ? CHANNELS
                                                                 : pcr_pkg::CH_SPACE;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = pcr_pkg::CNT_W;

  pcr_pkg::cfg_t cfg;

  pcr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );
  assign cfg_ready_o = 1'b1;

  // per-channel state
  logic [CW-1:0]                 cnt_q   [DEPTH];
  logic                          lvl_q   [DEPTH];
  logic [1:0]                    flag_q  [DEPTH];
  logic                          pend_q  [DEPTH];
  logic [pcr_pkg::HOLDCNT_W-1:0] hold_q  [DEPTH];
  logic [CW-1:0]                 rate_q  [DEPTH];
  logic [CW-1:0]                 wcnt_q  [DEPTH];
  logic [CW-1:0]                 wtime_q [DEPTH];
  logic [pcr_pkg::WIN_W-1:0]     wstep_q [DEPTH];

  pcr_pkg::state_e    state_q, state_d;
  pcr_pkg::in_item_t  item_q;
  pcr_pkg::out_item_t out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic               in_accept, out_load;

  logic [IDX_W-1:0] idx;
  logic             in_range;
  logic             wr_en;

  logic [CW-1:0]                 rd_cnt, rd_rate, rd_wcnt, rd_wtime;
  logic                          rd_lvl, rd_pend;
  logic [1:0]                    rd_flag;
  logic [pcr_pkg::HOLDCNT_W-1:0] rd_hold;
  logic [pcr_pkg::WIN_W-1:0]     rd_wstep;

  logic [CW-1:0]                 nx_cnt, nx_rate, nx_wcnt, nx_wtime;
  logic                          nx_lvl, nx_pend;
  logic [1:0]                    nx_flag;
  logic [pcr_pkg::HOLDCNT_W-1:0] nx_hold;
  logic [pcr_pkg::WIN_W-1:0]     nx_wstep;

  logic [CW-1:0] elapsed, delta, dividend;
  logic          div_start, div_done;
  logic [CW-1:0] quotient;

  assign idx      = IDX_W'(item_q.channel);
  assign in_range = 32'(item_q.channel) < DEPTH;

  assign rd_cnt   = cnt_q[idx];
  assign rd_lvl   = lvl_q[idx];
  assign rd_flag  = flag_q[idx];
  assign rd_pend  = pend_q[idx];
  assign rd_hold  = hold_q[idx];
  assign rd_rate  = rate_q[idx];
  assign rd_wcnt  = wcnt_q[idx];
  assign rd_wtime = wtime_q[idx];
  assign rd_wstep = wstep_q[idx];

  assign elapsed  = item_q.now_seconds - rd_wtime;
  assign delta    = rd_cnt - rd_wcnt;
  // delta * 60 modulo 2^32
  assign dividend = (delta << 6) - (delta << 2);

  // channel update for the addressed entry
  always_comb begin
    nx_cnt   = rd_cnt;
    nx_lvl   = rd_lvl;
    nx_flag  = rd_flag;
    nx_pend  = rd_pend;
    nx_hold  = rd_hold;
    nx_rate  = rd_rate;
    nx_wcnt  = rd_wcnt;
    nx_wtime = rd_wtime;
    nx_wstep = rd_wstep;
    div_start = 1'b0;
    case (item_q.opcode)
      pcr_pkg::OP_SAMPLE: begin
        case (rd_flag)
          pcr_pkg::RUN_START: begin
            if (item_q.sample > cfg.high_threshold) begin
              if (!rd_lvl) nx_cnt = rd_cnt + 1'b1;
              nx_lvl = 1'b1;
            end
            if (item_q.sample < cfg.low_threshold) nx_lvl = 1'b0;
          end
          pcr_pkg::RUN_CLEAR: nx_cnt = '0;
          default: nx_cnt = rd_cnt;
        endcase
        if (rd_pend) begin
          nx_flag = pcr_pkg::RUN_CLEAR;
          nx_hold = rd_hold + 1'b1;
          if (nx_hold > {1'b0, cfg.clear_hold}) begin
            nx_hold = '0;
            nx_pend = 1'b0;
          end
        end else begin
          nx_flag = item_q.count_mode ? pcr_pkg::RUN_START : pcr_pkg::RUN_STOP;
        end
      end
      pcr_pkg::OP_CLEAR: begin
        if (item_q.count_mode) begin
          nx_cnt  = '0;
          nx_rate = '0;
          nx_pend = 1'b1;
        end
      end
      pcr_pkg::OP_RPM: begin
        if (item_q.rpm_mode) begin
          if (rd_wcnt <= rd_cnt) begin
            div_start = (state_q == pcr_pkg::ST_EXEC) && in_range && (elapsed != '0);
            if (rd_wstep >= cfg.rpm_window) begin
              nx_wtime = item_q.now_seconds;
              nx_wcnt  = rd_cnt;
              nx_wstep = '0;
            end else begin
              nx_wstep = rd_wstep + 1'b1;
            end
          end else begin
            nx_wstep = '0;
            nx_wtime = item_q.now_seconds;
            nx_wcnt  = rd_cnt;
          end
        end
      end
      default: nx_cnt = rd_cnt;
    endcase
  end

  pcr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (elapsed),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    wr_en       = 1'b0;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    case (state_q)
      pcr_pkg::ST_IDLE: begin
        if (in_accept) state_d = pcr_pkg::ST_EXEC;
      end
      pcr_pkg::ST_EXEC: begin
        wr_en   = in_range;
        state_d = div_start ? pcr_pkg::ST_DIV : pcr_pkg::ST_RESULT;
      end
      pcr_pkg::ST_DIV: begin
        if (div_done) state_d = pcr_pkg::ST_RESULT;
      end
      pcr_pkg::ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.out_channel = item_q.channel;
          if (in_range) begin
            out_d.pulse_count = rd_cnt;
            out_d.rate_rpm    = rd_rate;
            out_d.level_high  = rd_lvl;
            out_d.run_state   = rd_flag;
          end
          state_d = pcr_pkg::ST_IDLE;
        end
      end
      default: state_d = pcr_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != pcr_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) item_q <= in_data_i;
    if (out_load) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        cnt_q[i]   <= '0;
        lvl_q[i]   <= 1'b1;
        flag_q[i]  <= pcr_pkg::RUN_STOP;
        pend_q[i]  <= 1'b0;
        hold_q[i]  <= '0;
        rate_q[i]  <= '0;
        wcnt_q[i]  <= '0;
        wtime_q[i] <= '0;
        wstep_q[i] <= '0;
      end
    end else begin
      if (wr_en) begin
        cnt_q[idx]   <= nx_cnt;
        lvl_q[idx]   <= nx_lvl;
        flag_q[idx]  <= nx_flag;
        pend_q[idx]  <= nx_pend;
        hold_q[idx]  <= nx_hold;
        rate_q[idx]  <= nx_rate;
        wcnt_q[idx]  <= nx_wcnt;
        wtime_q[idx] <= nx_wtime;
        wstep_q[idx] <= nx_wstep;
      end
      if (state_q == pcr_pkg::ST_DIV && div_done) rate_q[idx] <= quotient;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
